/* hdl/uida_pkg.sv */
// unique id allocator: shared types and constants
// no dependencies; imported by every module of the block
package uida_pkg;

    localparam int unsigned IdWidth = 32;
    localparam int unsigned ReqWidth = 2;
    localparam int unsigned StatusWidth = 2;

    localparam logic [IdWidth-1:0] LcgMul = 32'd1664525;
    localparam logic [IdWidth-1:0] LcgAdd = 32'd1013904223;
    localparam logic [IdWidth-1:0] SeedReset = 32'd1;

    typedef enum logic [ReqWidth-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_SET     = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_CHECK   = 2'd3
    } t_req;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic step;
    } t_lcg_ctl;

endpackage

/* hdl/uida_lcg.sv */
// unique id allocator: 32-bit lcg generator, registered multiply then add
// depends on uida_pkg
module uida_lcg
    import uida_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lcg_ctl           i_ctl,
    input  logic [IdWidth-1:0] i_seed,
    output logic [IdWidth-1:0] o_value
);

    logic [IdWidth-1:0] r_state;
    logic [IdWidth-1:0] r_prod;
    logic               r_add_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SeedReset;
            r_add_pend <= 1'b0;
        end else if (i_ctl.load) begin
            r_state    <= i_seed;
            r_add_pend <= 1'b0;
        end else if (r_add_pend) begin
            r_state    <= r_prod + LcgAdd;
            r_add_pend <= 1'b0;
        end else begin
            r_add_pend <= i_ctl.step;
        end
    end

    // product register, low 32 bits only
    always_ff @(posedge i_clk) begin
        r_prod <= r_state * LcgMul;
    end

    assign o_value = r_state;

endmodule

/* hdl/uida_store.sv */
// unique id allocator: id table memory, one write and one registered read port
// word holds {valid, id}; depends on uida_pkg
module uida_store
    import uida_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned AW = $clog2(TABLE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [IdWidth:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [IdWidth:0] o_rdata
);

    logic [IdWidth:0] r_mem [TABLE_DEPTH];
    logic [IdWidth:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/unique_id_allocator_core.sv */
// unique id allocator: top level with request sequencer and table scan
// depends on uida_pkg, uida_lcg, uida_store
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata id_value, tuser req_type
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata result_id, status, used_count
// cfg      in   i_cfg_valid/o_cfg_ready        i_cfg_data random_seed
//
// each candidate id costs one pass over the table through the single memory
// read port, and an allocate first draws its candidate from the generator
// release, check and set of a free id scan the table once; allocate draws first,
// and every redraw adds another draw and another pass
// a full table answers allocate or set without a scan
// after reset a clearing pass over every table word runs with s_axis_tready low
// one request at a time; a finished result waits in the output register
module unique_id_allocator_core
    import uida_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned AW = $clog2(TABLE_DEPTH),
    parameter int unsigned CW = $clog2(TABLE_DEPTH + 1),
    parameter int unsigned OW = ((IdWidth + StatusWidth + CW + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IdWidth-1:0]  s_axis_tdata,   // id_value
    input  logic [ReqWidth-1:0] s_axis_tuser,   // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OW-1:0]       m_axis_tdata,   // result_id, status, used_count, zero pad
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IdWidth-1:0]  i_cfg_data      // random_seed
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_DRAW_WAIT,
        S_DRAW_LOAD,
        S_SCAN,
        S_SCAN_TAIL,
        S_DECIDE,
        S_FINISH
    } t_state;

    localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

    t_state             r_state;
    t_req               r_req;
    logic [IdWidth-1:0] r_cand;
    logic [AW-1:0]      r_addr;
    logic               r_rd_pend;
    logic [AW-1:0]      r_rd_idx;
    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic               r_free_found;
    logic [AW-1:0]      r_free_idx;
    logic [CW-1:0]      r_count;
    logic [IdWidth-1:0] r_res_id;
    t_status            r_res_status;
    logic               r_m_valid;
    logic [IdWidth-1:0] r_out_id;
    t_status            r_out_status;
    logic [CW-1:0]      r_out_count;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [IdWidth:0]   mem_wdata;
    logic [IdWidth:0]   mem_rdata;
    t_lcg_ctl           lcg_ctl;
    logic [IdWidth-1:0] lcg_value;
    logic               cand_free;
    logic               in_beat;
    logic               out_load;

    uida_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .AW(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_addr),
        .o_rdata(mem_rdata)
    );

    uida_lcg u_lcg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (lcg_ctl),
        .i_seed (i_cfg_data),
        .o_value(lcg_value)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign cand_free     = (r_cand != '0) && !r_hit;
    assign out_load      = (r_state == S_FINISH) && (!r_m_valid || m_axis_tready);

    assign lcg_ctl.load = i_cfg_valid;
    assign lcg_ctl.step = (r_state == S_DRAW);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_DECIDE: begin
                if ((r_req == REQ_ALLOC || r_req == REQ_SET) && cand_free && r_free_found) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_free_idx;
                    mem_wdata = {1'b1, r_cand};
                end else if (r_req == REQ_RELEASE && r_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hit_idx;
                    mem_wdata = {1'b0, r_cand};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // compare unit: one table word per cycle
            if (r_rd_pend) begin
                if (mem_rdata[IdWidth] && mem_rdata[IdWidth-1:0] == r_cand) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
                if (!mem_rdata[IdWidth] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_rd_idx;
                end
            end

            if (out_load) begin
                r_m_valid    <= 1'b1;
                r_out_id     <= r_res_id;
                r_out_status <= r_res_status;
                r_out_count  <= r_count;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LastAddr) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_beat) begin
                        r_req        <= t_req'(s_axis_tuser);
                        r_cand       <= s_axis_tdata;
                        r_addr       <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        if ((t_req'(s_axis_tuser) == REQ_ALLOC
                                || t_req'(s_axis_tuser) == REQ_SET)
                                && r_count == FullCount) begin
                            r_res_id     <= '0;
                            r_res_status <= ST_FULL;
                            r_state      <= S_FINISH;
                        end else if (t_req'(s_axis_tuser) == REQ_ALLOC) begin
                            r_state <= S_DRAW;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_DRAW: begin
                    r_state <= S_DRAW_WAIT;
                end
                S_DRAW_WAIT: begin
                    r_state <= S_DRAW_LOAD;
                end
                S_DRAW_LOAD: begin
                    r_cand       <= lcg_value;
                    r_addr       <= '0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_state      <= S_SCAN;
                end
                S_SCAN: begin
                    r_rd_pend <= 1'b1;
                    r_rd_idx  <= r_addr;
                    if (r_addr == LastAddr) begin
                        r_addr  <= '0;
                        r_state <= S_SCAN_TAIL;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_SCAN_TAIL: begin
                    r_rd_pend <= 1'b0;
                    r_state   <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_res_id <= r_cand;
                    case (r_req)
                        REQ_ALLOC, REQ_SET: begin
                            if (cand_free && r_free_found) begin
                                r_count      <= r_count + 1'b1;
                                r_res_status <= ST_OK;
                                r_state      <= S_FINISH;
                            end else begin
                                r_state <= S_DRAW;
                            end
                        end
                        REQ_RELEASE: begin
                            r_state <= S_FINISH;
                            if (r_hit) begin
                                r_count      <= r_count - 1'b1;
                                r_res_status <= ST_OK;
                            end else begin
                                r_res_status <= ST_MISS;
                            end
                        end
                        default: begin
                            r_state      <= S_FINISH;
                            r_res_status <= cand_free ? ST_OK : ST_MISS;
                        end
                    endcase
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OW'({r_out_count, r_out_status, r_out_id});

endmodule

/* hdl/uida_checker.sv */
// unique id allocator: port-level checks on the top level
// depends on uida_pkg; bound to unique_id_allocator_core below
module uida_checker
    import uida_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned CW = $clog2(TABLE_DEPTH + 1),
    parameter int unsigned OW = ((IdWidth + StatusWidth + CW + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [OW-1:0] m_axis_tdata
);

    localparam int unsigned StLo = IdWidth;
    localparam int unsigned CntLo = IdWidth + StatusWidth;

    // one request at a time: busy right after an input beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[StLo+StatusWidth-1:StLo] != 2'd3)
        else $error("undefined status code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[CntLo+CW-1:CntLo] <= CW'(TABLE_DEPTH))
        else $error("used count above table depth");

    a_full_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[StLo+StatusWidth-1:StLo] == ST_FULL
        |-> m_axis_tdata[IdWidth-1:0] == '0 && m_axis_tdata[CntLo+CW-1:CntLo] == CW'(TABLE_DEPTH))
        else $error("full status with nonzero id or count below depth");

endmodule

bind unique_id_allocator_core uida_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_uida_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
